// File: rtl/csrcc_pkg.sv
`timescale 1ns / 1ps

package csrcc_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 8192;

  localparam int OP_W    = 2;
  localparam int INDEX_W = 14;
  localparam int VALUE_W = 14;
  localparam int COUNT_W = 11;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_OFFSET = 2'd0,
    OP_LOAD_ADJ    = 2'd1,
    OP_RUN         = 2'd2,
    OP_READ        = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_TOP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_VO_RD,
    S_VO_DATA,
    S_OFF_LO,
    S_OFF_HI,
    S_EDGE_TEST,
    S_EDGE_J,
    S_EDGE_M,
    S_FINISH,
    S_RD_WAIT
  } walk_state_t;

  typedef struct packed {
    logic run;
    logic rd;
  } walk_cmd_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } walk_status_t;

endpackage

// File: rtl/csr_bfs_connected_components_core.sv
`timescale 1ns / 1ps

// Connected-component labelling of a graph in compressed sparse row form.
// One input channel (in_*) carries four kinds of beat, chosen by in_op:
// load offset and load adjacency entry fill the graph stores and return nothing;
// a run beat walks the graph breadth-first and returns one result beat; a read
// beat returns the visit-order entry and component start at in_index.
// Load beats may follow back to back while no run or read is in progress and no
// result waits under out_stall. A read result is set up in the S_RD_WAIT state
// and then held in the output register. Every step of a run waits on a
// registered read of the unvisited flags, visit order, offset or adjacency
// memory, each with one read port and one write port.
// The result channel (out_*) is held in an output register; while a result
// waits under out_stall, further input beats are stalled.
// Reset clears the component count, error flag and last node count; the graph
// stores and result memories hold nothing defined until written. Each run
// first sweeps its n unvisited flags, one per cycle, before the walk begins.
module csr_bfs_connected_components_core #(
  parameter int MAX_NODES = csrcc_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = csrcc_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [csrcc_pkg::OP_W-1:0]    in_op,
  input  logic [csrcc_pkg::INDEX_W-1:0] in_index,
  input  logic [csrcc_pkg::VALUE_W-1:0] in_value,
  input  logic [csrcc_pkg::COUNT_W-1:0] in_node_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [csrcc_pkg::COUNT_W-1:0] out_component_count,
  output logic [csrcc_pkg::COUNT_W-1:0] out_order_entry,
  output logic [csrcc_pkg::COUNT_W-1:0] out_component_start,
  output logic                          out_error
);

  import csrcc_pkg::*;

  localparam int NW  = $clog2(MAX_NODES + 1);
  localparam int JW  = $clog2(MAX_NODES + 2);
  localparam int EAW = $clog2(MAX_EDGES);

  logic               accept;
  walk_cmd_t          cmd;
  walk_status_t       status;
  logic [NW-1:0]      res_count, res_entry, res_start;
  logic               res_error;
  logic [NW-1:0]      off_raddr;
  logic [VALUE_W-1:0] off_rdata;
  logic [EAW-1:0]     adj_raddr;
  logic [JW-1:0]      adj_rdata;

  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] count_r, entry_r, start_r;
  logic               error_r;

  assign in_stall = !status.idle || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign cmd.run  = accept && (op_t'(in_op) == OP_RUN);
  assign cmd.rd   = accept && (op_t'(in_op) == OP_READ);

  csrcc_graph_store #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_graph_store (
    .clk       (clk),
    .load_en   (accept),
    .op        (in_op),
    .index     (in_index),
    .value     (in_value),
    .off_raddr (off_raddr),
    .off_rdata (off_rdata),
    .adj_raddr (adj_raddr),
    .adj_rdata (adj_rdata)
  );

  csrcc_walk #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_index (in_index),
    .cmd_nodes (in_node_count),
    .status    (status),
    .res_count (res_count),
    .res_entry (res_entry),
    .res_start (res_start),
    .res_error (res_error),
    .off_raddr (off_raddr),
    .off_rdata (off_rdata),
    .adj_raddr (adj_raddr),
    .adj_rdata (adj_rdata)
  );

  assign out_valid_nxt = status.res_valid || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (status.res_valid) begin
      count_r <= COUNT_W'(res_count);
      entry_r <= COUNT_W'(res_entry);
      start_r <= COUNT_W'(res_start);
      error_r <= res_error;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_component_count = count_r;
  assign out_order_entry     = entry_r;
  assign out_component_start = start_r;
  assign out_error           = error_r;

endmodule

// File: rtl/csrcc_graph_store.sv
`timescale 1ns / 1ps

module csrcc_graph_store #(
  parameter int MAX_NODES = csrcc_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = csrcc_pkg::MAX_EDGES_DEF,
  localparam int NW  = $clog2(MAX_NODES + 1),
  localparam int JW  = $clog2(MAX_NODES + 2),
  localparam int EAW = $clog2(MAX_EDGES)
) (
  input  logic                          clk,
  input  logic                          load_en,
  input  logic [csrcc_pkg::OP_W-1:0]    op,
  input  logic [csrcc_pkg::INDEX_W-1:0] index,
  input  logic [csrcc_pkg::VALUE_W-1:0] value,
  input  logic [NW-1:0]                 off_raddr,
  output logic [csrcc_pkg::VALUE_W-1:0] off_rdata,
  input  logic [EAW-1:0]                adj_raddr,
  output logic [JW-1:0]                 adj_rdata
);

  import csrcc_pkg::*;

  logic [VALUE_W-1:0] off_mem [MAX_NODES + 1];
  logic [JW-1:0]      adj_mem [MAX_EDGES];

  logic [31:0]        idx_ext;
  logic               off_we;
  logic               adj_we;
  logic [JW-1:0]      adj_wdata;
  logic [VALUE_W-1:0] off_rdata_r;
  logic [JW-1:0]      adj_rdata_r;

  assign idx_ext = 32'(index);
  assign off_we  = load_en && (op_t'(op) == OP_LOAD_OFFSET) && (idx_ext <= 32'(MAX_NODES));
  assign adj_we  = load_en && (op_t'(op) == OP_LOAD_ADJ) && (idx_ext < 32'(MAX_EDGES));

  // Neighbor numbers past the node limit collapse to one value that is always out of range.
  assign adj_wdata = (32'(value) > 32'(MAX_NODES)) ? JW'(MAX_NODES + 1) : JW'(value);

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[idx_ext[NW-1:0]] <= value;
    end
    off_rdata_r <= off_mem[off_raddr];
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[idx_ext[EAW-1:0]] <= adj_wdata;
    end
    adj_rdata_r <= adj_mem[adj_raddr];
  end

  assign off_rdata = off_rdata_r;
  assign adj_rdata = adj_rdata_r;

endmodule

// File: rtl/csrcc_walk.sv
`timescale 1ns / 1ps

module csrcc_walk #(
  parameter int MAX_NODES = csrcc_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = csrcc_pkg::MAX_EDGES_DEF,
  localparam int NW  = $clog2(MAX_NODES + 1),
  localparam int JW  = $clog2(MAX_NODES + 2),
  localparam int EAW = $clog2(MAX_EDGES)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  csrcc_pkg::walk_cmd_t          cmd,
  input  logic [csrcc_pkg::INDEX_W-1:0] cmd_index,
  input  logic [csrcc_pkg::COUNT_W-1:0] cmd_nodes,
  output csrcc_pkg::walk_status_t       status,
  output logic [NW-1:0]                 res_count,
  output logic [NW-1:0]                 res_entry,
  output logic [NW-1:0]                 res_start,
  output logic                          res_error,
  output logic [NW-1:0]                 off_raddr,
  input  logic [csrcc_pkg::VALUE_W-1:0] off_rdata,
  output logic [EAW-1:0]                adj_raddr,
  input  logic [JW-1:0]                 adj_rdata
);

  import csrcc_pkg::*;

  localparam int NAW = $clog2(MAX_NODES);
  localparam int EW  = $clog2(MAX_EDGES + 2);
  localparam int PW  = (EW > VALUE_W) ? EW : VALUE_W;

  // Unvisited flags, visit order and component start positions.
  logic          mask_mem [MAX_NODES];
  logic [NW-1:0] vo_mem   [MAX_NODES];
  logic [NW-1:0] cs_mem   [MAX_NODES + 1];

  logic           mask_we, mask_wdata, mask_rdata_r;
  logic [NAW-1:0] mask_waddr, mask_raddr;
  logic           vo_we;
  logic [NAW-1:0] vo_waddr, vo_raddr;
  logic [NW-1:0]  vo_wdata, vo_rdata_r;
  logic           cs_we;
  logic [NW-1:0]  cs_waddr, cs_raddr, cs_wdata, cs_rdata_r;

  walk_state_t        state_r, state_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [NW-1:0]      last_nodes_r, last_nodes_nxt;
  logic [NW-1:0]      count_r, count_nxt;
  logic [NW-1:0]      head_r, head_nxt;
  logic [NW-1:0]      scan_r, scan_nxt;
  logic [NW-1:0]      comps_r, comps_nxt;
  logic [NW-1:0]      comps_found_r, comps_found_nxt;
  logic               error_r, error_nxt;
  logic [NW-1:0]      v_r, v_nxt;
  logic [VALUE_W-1:0] lo_r, lo_nxt;
  logic [PW-1:0]      p_r, p_nxt;
  logic [PW-1:0]      hi_r, hi_nxt;
  logic [JW-1:0]      j_r, j_nxt;
  logic               entry_ok_r, entry_ok_nxt;
  logic               start_ok_r, start_ok_nxt;

  logic [31:0]   idx_ext;
  logic [NW-1:0] n_sat;
  logic [PW-1:0] p_m1, lo_ext, hi_ext;
  logic [NW-1:0] v_m1;
  logic [JW-1:0] j_m1, j_r_m1;
  logic          res_valid;

  assign idx_ext = 32'(cmd_index);
  assign n_sat   = (32'(cmd_nodes) > 32'(MAX_NODES)) ? NW'(MAX_NODES) : NW'(cmd_nodes);
  assign p_m1    = p_r - PW'(1);
  assign v_m1    = vo_rdata_r - NW'(1);
  assign j_m1    = adj_rdata - JW'(1);
  assign j_r_m1  = j_r - JW'(1);
  assign lo_ext  = PW'(lo_r);
  assign hi_ext  = PW'(off_rdata);

  always_ff @(posedge clk) begin
    if (mask_we) begin
      mask_mem[mask_waddr] <= mask_wdata;
    end
    mask_rdata_r <= mask_mem[mask_raddr];
  end

  always_ff @(posedge clk) begin
    if (vo_we) begin
      vo_mem[vo_waddr] <= vo_wdata;
    end
    vo_rdata_r <= vo_mem[vo_raddr];
  end

  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem[cs_waddr] <= cs_wdata;
    end
    cs_rdata_r <= cs_mem[cs_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      last_nodes_r  <= '0;
      comps_found_r <= '0;
      error_r       <= 1'b0;
      n_r           <= '0;
      count_r       <= '0;
      head_r        <= '0;
      scan_r        <= '0;
      comps_r       <= '0;
      entry_ok_r    <= 1'b0;
      start_ok_r    <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      last_nodes_r  <= last_nodes_nxt;
      comps_found_r <= comps_found_nxt;
      error_r       <= error_nxt;
      n_r           <= n_nxt;
      count_r       <= count_nxt;
      head_r        <= head_nxt;
      scan_r        <= scan_nxt;
      comps_r       <= comps_nxt;
      entry_ok_r    <= entry_ok_nxt;
      start_ok_r    <= start_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r  <= v_nxt;
    lo_r <= lo_nxt;
    p_r  <= p_nxt;
    hi_r <= hi_nxt;
    j_r  <= j_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    last_nodes_nxt  = last_nodes_r;
    comps_found_nxt = comps_found_r;
    error_nxt       = error_r;
    n_nxt           = n_r;
    count_nxt       = count_r;
    head_nxt        = head_r;
    scan_nxt        = scan_r;
    comps_nxt       = comps_r;
    entry_ok_nxt    = entry_ok_r;
    start_ok_nxt    = start_ok_r;
    v_nxt           = v_r;
    lo_nxt          = lo_r;
    p_nxt           = p_r;
    hi_nxt          = hi_r;
    j_nxt           = j_r;

    mask_we    = 1'b0;
    mask_waddr = scan_r[NAW-1:0];
    mask_wdata = 1'b0;
    mask_raddr = scan_r[NAW-1:0];
    vo_we      = 1'b0;
    vo_waddr   = count_r[NAW-1:0];
    vo_wdata   = NW'(j_r);
    vo_raddr   = head_r[NAW-1:0];
    cs_we      = 1'b0;
    cs_waddr   = comps_r;
    cs_wdata   = count_r;
    cs_raddr   = idx_ext[NW-1:0];
    off_raddr  = v_r;
    adj_raddr  = p_m1[EAW-1:0];
    res_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        vo_raddr = idx_ext[NAW-1:0];
        if (cmd.run) begin
          n_nxt           = n_sat;
          last_nodes_nxt  = n_sat;
          error_nxt       = 1'b0;
          comps_found_nxt = '0;
          count_nxt       = '0;
          head_nxt        = '0;
          scan_nxt        = '0;
          comps_nxt       = '0;
          entry_ok_nxt    = 1'b0;
          start_ok_nxt    = 1'b0;
          state_nxt       = (n_sat == '0) ? S_FINISH : S_CLEAR;
        end else if (cmd.rd) begin
          entry_ok_nxt = idx_ext < 32'(last_nodes_r);
          start_ok_nxt = (last_nodes_r != '0) && (idx_ext <= 32'(comps_found_r));
          state_nxt    = S_RD_WAIT;
        end
      end

      // Mark nodes 1..n unvisited, one entry a cycle; scan_r doubles as the sweep counter.
      S_CLEAR: begin
        mask_we    = 1'b1;
        mask_wdata = 1'b1;
        if (scan_r == n_r - NW'(1)) begin
          scan_nxt  = '0;
          state_nxt = S_TOP;
        end else begin
          scan_nxt = scan_r + NW'(1);
        end
      end

      S_TOP: begin
        if (head_r >= n_r) begin
          state_nxt = S_FINISH;
        end else if (head_r == count_r) begin
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_VO_RD;
        end
      end

      S_SCAN_RD: begin
        if (scan_r >= n_r) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end

      // The queue ran dry: the lowest unvisited node opens a new component.
      S_SCAN_CHK: begin
        if (mask_rdata_r) begin
          cs_we     = 1'b1;
          comps_nxt = comps_r + NW'(1);
          mask_we   = 1'b1;
          vo_we     = 1'b1;
          vo_wdata  = scan_r + NW'(1);
          count_nxt = count_r + NW'(1);
          state_nxt = S_VO_RD;
        end else begin
          scan_nxt  = scan_r + NW'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      S_VO_RD: begin
        head_nxt  = head_r + NW'(1);
        state_nxt = S_VO_DATA;
      end

      S_VO_DATA: begin
        v_nxt     = vo_rdata_r;
        off_raddr = v_m1;
        state_nxt = S_OFF_LO;
      end

      S_OFF_LO: begin
        lo_nxt    = off_rdata;
        off_raddr = v_r;
        state_nxt = S_OFF_HI;
      end

      // Clip the row range to adjacency positions 1..MAX_EDGES.
      S_OFF_HI: begin
        p_nxt     = (lo_ext == '0) ? PW'(1) : lo_ext;
        hi_nxt    = (hi_ext > PW'(MAX_EDGES + 1)) ? PW'(MAX_EDGES + 1) : hi_ext;
        state_nxt = S_EDGE_TEST;
      end

      S_EDGE_TEST: begin
        if (p_r < hi_r) begin
          state_nxt = S_EDGE_J;
        end else begin
          state_nxt = S_TOP;
        end
      end

      S_EDGE_J: begin
        if ((adj_rdata == '0) || (adj_rdata > JW'(n_r))) begin
          error_nxt = 1'b1;
          p_nxt     = p_r + PW'(1);
          state_nxt = S_EDGE_TEST;
        end else begin
          j_nxt      = adj_rdata;
          mask_raddr = j_m1[NAW-1:0];
          state_nxt  = S_EDGE_M;
        end
      end

      S_EDGE_M: begin
        if (mask_rdata_r) begin
          mask_we    = 1'b1;
          mask_waddr = j_r_m1[NAW-1:0];
          vo_we      = 1'b1;
          count_nxt  = count_r + NW'(1);
        end
        p_nxt     = p_r + PW'(1);
        state_nxt = S_EDGE_TEST;
      end

      S_FINISH: begin
        cs_we           = 1'b1;
        cs_wdata        = n_r;
        comps_found_nxt = comps_r;
        res_valid       = 1'b1;
        state_nxt       = S_IDLE;
      end

      S_RD_WAIT: begin
        res_valid = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign status.idle      = (state_r == S_IDLE);
  assign status.res_valid = res_valid;

  assign res_count = (state_r == S_FINISH) ? comps_r : comps_found_r;
  assign res_entry = ((state_r == S_RD_WAIT) && entry_ok_r) ? vo_rdata_r : '0;
  assign res_start = ((state_r == S_RD_WAIT) && start_ok_r) ? cs_rdata_r : '0;
  assign res_error = error_r;

endmodule
